// ===== src/block_buffer_cache_manager_core_assert.svh =====
// assertion macros for the buffer cache manager
// no dependencies
`ifndef BLOCK_BUFFER_CACHE_MANAGER_CORE_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_CORE_ASSERT_SVH
`define BBCM_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BBCM_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== src/bbcm_pkg.sv =====
// package for the buffer cache manager: constants, codes and cell types
// no dependencies
package bbcm_pkg;
    localparam int NUM_BUFFERS_DEF = 32;
    localparam int IDX_W = 5;
    localparam int CNT_W = 6;

    typedef enum logic [2:0] {
        RK_HIT = 3'd0, RK_FRESH = 3'd1, RK_WRITEBACK = 3'd2, RK_WAIT_BUSY = 3'd3,
        RK_WAIT_ANY = 3'd4, RK_RELEASED = 3'd5, RK_REJECTED = 3'd6
    } result_kind_t;

    localparam int MK_INVALID = 0;
    localparam int MK_BUSY = 1;
    localparam int MK_ONDEMAND = 2;
    localparam int MK_DELAYED = 3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOKUP, ST_RELEASE, ST_HEAD, ST_DONE
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic        lookup;
        logic        hit_busy;
        logic        hit_free;
        logic [IDX_W-1:0] hit_idx;
        logic        take;
        logic        retag;
        logic [IDX_W-1:0] take_idx;
        logic        rel;
        logic [IDX_W-1:0] rel_idx;
        logic        rel_good;
        logic        rel_dw;
        logic [15:0] dev;
        logic [31:0] blk;
    } cell_cmd_t;

    // match scan result carried along the chain
    typedef struct packed {
        logic        found;
        logic [IDX_W-1:0] idx;
    } scan_t;
endpackage

// ===== src/bbcm_cell.sv =====
// one buffer header cell: tag, assigned flag and status marks
// depends on bbcm_pkg
module bbcm_cell #(
    parameter int MY_IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bbcm_pkg::cell_cmd_t cmd,
    input  bbcm_pkg::scan_t     scan_in,
    output bbcm_pkg::scan_t     scan_out,
    output logic [3:0]          marks
);
    import bbcm_pkg::*;

    logic [15:0] dev_reg;
    logic [31:0] blk_reg;
    logic        asg_reg;
    logic [3:0]  marks_reg;
    logic [3:0]  marks_next;
    logic        match;
    localparam logic [IDX_W-1:0] ME = IDX_W'(MY_IDX);

    assign match = asg_reg && dev_reg == cmd.dev && blk_reg == cmd.blk;
    assign marks = marks_reg;

    // first match wins: lower index cells pass found downstream
    always_comb
    begin
        scan_out = scan_in;
        if (!scan_in.found && match)
        begin
            scan_out.found = 1'b1;
            scan_out.idx = ME;
        end
    end

    always_comb
    begin
        marks_next = marks_reg;
        if (cmd.hit_busy && cmd.hit_idx == ME)
            marks_next[MK_ONDEMAND] = 1'b1;
        if (cmd.hit_free && cmd.hit_idx == ME)
            marks_next[MK_BUSY] = 1'b1;
        if (cmd.take && cmd.take_idx == ME)
        begin
            marks_next[MK_BUSY] = 1'b1;
            if (cmd.retag)
                marks_next[MK_INVALID] = 1'b1;
        end
        if (cmd.rel && cmd.rel_idx == ME)
        begin
            marks_next = '0;
            marks_next[MK_INVALID] = !cmd.rel_good;
            marks_next[MK_DELAYED] = cmd.rel_dw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asg_reg <= 1'b0;
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
            if (cmd.take && cmd.retag && cmd.take_idx == ME)
                asg_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && cmd.retag && cmd.take_idx == ME)
        begin
            dev_reg <= cmd.dev;
            blk_reg <= cmd.blk;
        end
    end
endmodule

// ===== src/bbcm_freelist.sv =====
// lru free list kept as linked index arrays with head, tail and count
// depends on bbcm_pkg
module bbcm_freelist #(
    parameter int NUM_BUFFERS = bbcm_pkg::NUM_BUFFERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       remove,
    input  logic [bbcm_pkg::IDX_W-1:0] remove_idx,
    input  logic                       insert,
    input  logic                       insert_tail,
    input  logic [bbcm_pkg::IDX_W-1:0] insert_idx,
    output logic [bbcm_pkg::IDX_W-1:0] head,
    output logic [bbcm_pkg::CNT_W-1:0] count
);
    import bbcm_pkg::*;

    logic [IDX_W-1:0] next_reg [NUM_BUFFERS];
    logic [IDX_W-1:0] prev_reg [NUM_BUFFERS];
    logic [IDX_W-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [NUM_BUFFERS-1:0] on_reg;

    assign head = head_reg;
    assign count = count_reg;

    function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] v);
        logic [IDX_W:0] w;
        w = {1'b0, v};
        if (w >= (IDX_W+1)'(NUM_BUFFERS))
            w = w - (IDX_W+1)'(NUM_BUFFERS);
        return w[IDX_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                next_reg[i] <= IDX_W'(i + 1);
                prev_reg[i] <= IDX_W'(i - 1);
            end
            head_reg <= '0;
            tail_reg <= IDX_W'(NUM_BUFFERS - 1);
            count_reg <= CNT_W'(NUM_BUFFERS);
            on_reg <= '1;
        end
        else if (remove && on_reg[remove_idx] && count_reg != '0)
        begin
            if (count_reg == CNT_W'(1))
                count_reg <= '0;
            else if (remove_idx == head_reg)
            begin
                head_reg <= next_reg[remove_idx];
                count_reg <= count_reg - 1'b1;
            end
            else if (remove_idx == tail_reg)
            begin
                tail_reg <= prev_reg[remove_idx];
                count_reg <= count_reg - 1'b1;
            end
            else
            begin
                next_reg[wrap(prev_reg[remove_idx])] <= wrap(next_reg[remove_idx]);
                prev_reg[wrap(next_reg[remove_idx])] <= wrap(prev_reg[remove_idx]);
                count_reg <= count_reg - 1'b1;
            end
            on_reg[remove_idx] <= 1'b0;
        end
        else if (insert && !on_reg[insert_idx])
        begin
            if (count_reg == '0)
            begin
                head_reg <= insert_idx;
                tail_reg <= insert_idx;
            end
            else if (insert_tail)
            begin
                next_reg[wrap(tail_reg)] <= insert_idx;
                prev_reg[insert_idx] <= tail_reg;
                tail_reg <= insert_idx;
            end
            else
            begin
                prev_reg[wrap(head_reg)] <= insert_idx;
                next_reg[insert_idx] <= head_reg;
                head_reg <= insert_idx;
            end
            count_reg <= count_reg + 1'b1;
            on_reg[insert_idx] <= 1'b1;
        end
    end
endmodule

// ===== src/block_buffer_cache_manager_core.sv =====
// buffer cache manager: getblk / brelse over a fixed pool of buffer headers
// a get runs a lookup pass over the cell chain; on a miss it then takes one
// free-list head per cycle, with a write-back result for each delayed-write
// buffer before the final one. results are one-cycle strobes on
// result_valid and cannot be stalled; busy stays high until the last one
// depends on bbcm_pkg, bbcm_cell, bbcm_freelist
`include "block_buffer_cache_manager_core_assert.svh"
module block_buffer_cache_manager_core #(
    parameter int NUM_BUFFERS = bbcm_pkg::NUM_BUFFERS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       command,
    input  logic [15:0]                device_number,
    input  logic [31:0]                block_number,
    input  logic [4:0]                 buffer_index,
    input  logic                       contents_valid,
    input  logic                       delayed_write,
    output logic                       result_valid,
    output logic [2:0]                 result_kind,
    output logic [4:0]                 granted_buffer,
    output logic                       waiters_pending,
    output logic                       last
);
    import bbcm_pkg::*;

    state_t state_reg, state_next;
    logic [15:0] dev_reg;
    logic [31:0] blk_reg;
    logic [IDX_W-1:0] idx_reg;
    logic good_reg, dw_reg;
    scan_t hit_reg;

    logic rv_reg;
    logic [2:0] rk_reg;
    logic [4:0] gb_reg;
    logic wp_reg, last_reg;

    cell_cmd_t cmd;
    scan_t chain [NUM_BUFFERS+1];
    logic [3:0] marks [NUM_BUFFERS];
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] count;

    logic emit;
    logic [2:0] kind;
    logic [4:0] gbuf;
    logic wp, fin;
    logic fl_remove, fl_insert;
    logic [IDX_W-1:0] fl_remove_idx;
    logic rel_ok;

    assign chain[0] = '0;
    for (genvar g = 0; g < NUM_BUFFERS; g++)
    begin : g_cell
        bbcm_cell #(.MY_IDX(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .cmd(cmd),
            .scan_in(chain[g]), .scan_out(chain[g+1]), .marks(marks[g])
        );
    end

    bbcm_freelist #(.NUM_BUFFERS(NUM_BUFFERS)) u_free (
        .clk(clk), .rst_n(rst_n),
        .remove(fl_remove), .remove_idx(fl_remove_idx),
        .insert(fl_insert), .insert_tail(good_reg && !dw_reg), .insert_idx(idx_reg),
        .head(head), .count(count)
    );

    assign busy = state_reg != ST_IDLE;
    assign rel_ok = {1'b0, idx_reg} < 6'(NUM_BUFFERS)
        && marks[idx_reg][MK_BUSY];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = command ? ST_RELEASE : ST_LOOKUP;
            ST_LOOKUP:
                state_next = hit_reg.found ? ST_DONE : ST_HEAD;
            ST_RELEASE:
                state_next = ST_DONE;
            ST_HEAD:
                if (count == '0 || !marks[head][MK_DELAYED])
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        // tag match runs on the incoming transaction while idle
        cmd.dev = (state_reg == ST_IDLE) ? device_number : dev_reg;
        cmd.blk = (state_reg == ST_IDLE) ? block_number : blk_reg;
        emit = 1'b0;
        kind = RK_WAIT_ANY;
        gbuf = '0;
        wp = 1'b0;
        fin = 1'b1;
        fl_remove = 1'b0;
        fl_remove_idx = head;
        fl_insert = 1'b0;
        case (state_reg)
            ST_LOOKUP:
            begin
                if (hit_reg.found)
                begin
                    emit = 1'b1;
                    gbuf = 5'(hit_reg.idx);
                    if (marks[hit_reg.idx][MK_BUSY])
                    begin
                        cmd.hit_busy = 1'b1;
                        kind = RK_WAIT_BUSY;
                    end
                    else
                    begin
                        cmd.hit_free = 1'b1;
                        kind = RK_HIT;
                        fl_remove = 1'b1;
                    end
                    cmd.hit_idx = hit_reg.idx;
                    fl_remove_idx = hit_reg.idx;
                end
            end
            ST_RELEASE:
            begin
                emit = 1'b1;
                gbuf = 5'(idx_reg);
                if (rel_ok)
                begin
                    kind = RK_RELEASED;
                    wp = marks[idx_reg][MK_ONDEMAND];
                    cmd.rel = 1'b1;
                    fl_insert = 1'b1;
                end
                else
                    kind = RK_REJECTED;
                cmd.rel_idx = idx_reg;
                cmd.rel_good = good_reg;
                cmd.rel_dw = dw_reg;
            end
            ST_HEAD:
            begin
                emit = 1'b1;
                if (count != '0)
                begin
                    gbuf = 5'(head);
                    cmd.take = 1'b1;
                    cmd.take_idx = head;
                    fl_remove = 1'b1;
                    if (marks[head][MK_DELAYED])
                    begin
                        kind = RK_WRITEBACK;
                        fin = 1'b0;
                    end
                    else
                    begin
                        kind = RK_FRESH;
                        cmd.retag = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg <= 1'b0;
            hit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg <= chain[NUM_BUFFERS];
            rv_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            dev_reg <= device_number;
            blk_reg <= block_number;
            idx_reg <= buffer_index;
            good_reg <= contents_valid;
            dw_reg <= delayed_write;
        end
        rk_reg <= kind;
        gb_reg <= gbuf;
        wp_reg <= wp;
        last_reg <= fin;
    end

    assign result_valid = rv_reg;
    assign result_kind = rk_reg;
    assign granted_buffer = gb_reg;
    assign waiters_pending = wp_reg;
    assign last = last_reg;

    `BBCM_ASSERT_IMPL(a_idle_quiet, state_reg == ST_IDLE, !emit)
    `BBCM_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(NUM_BUFFERS))
    `BBCM_ASSERT_NEXT(a_last_ends, result_valid && last, !busy)
endmodule

// ===== tb/tb_block_buffer_cache_manager_core.sv =====
// testbench for block_buffer_cache_manager_core: directed and random get and release
// commands, with results predicted by a scoreboard class and checked field by field
// depends on bbcm_pkg and block_buffer_cache_manager_core
`timescale 1ns / 100ps
module tb_block_buffer_cache_manager_core;
    import bbcm_pkg::*;

    localparam int NB = NUM_BUFFERS_DEF;
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        result_kind_t    kind;
        logic [4:0]      buf_idx;
        logic            waiters;
        logic            fin;
    } cache_result_t;

    int error_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    class cache_scoreboard;
        logic [15:0] tag_dev [NB];
        logic [31:0] tag_blk [NB];
        bit          assigned_mk [NB];
        bit          invalid_mk [NB];
        bit          busy_mk [NB];
        bit          ondemand_mk [NB];
        bit          delayed_mk [NB];
        int          free_list [$];
        cache_result_t pending [$];

        function new();
            for (int i = 0; i < NB; i++)
            begin
                assigned_mk[i] = 0;
                invalid_mk[i] = 0;
                busy_mk[i] = 0;
                ondemand_mk[i] = 0;
                delayed_mk[i] = 0;
                free_list.push_back(i);
            end
        endfunction

        function void push(result_kind_t k, int b, bit w, bit f);
            cache_result_t r;
            r.kind = k;
            r.buf_idx = b[4:0];
            r.waiters = w;
            r.fin = f;
            pending.push_back(r);
        endfunction

        function void drop_free(int i);
            foreach (free_list[j])
            begin
                if (free_list[j] == i)
                begin
                    free_list.delete(j);
                    break;
                end
            end
        endfunction

        function bit on_list(int i);
            foreach (free_list[j])
                if (free_list[j] == i)
                    return 1;
            return 0;
        endfunction

        function void note_transaction(logic cmd, logic [15:0] dev, logic [31:0] blk,
                                       logic [4:0] idx, logic good, logic dw);
            int h;
            if (cmd == CMD_RELEASE)
            begin
                if (idx >= NB || !busy_mk[idx])
                begin
                    push(RK_REJECTED, int'(idx), 0, 1);
                    return;
                end
                push(RK_RELEASED, int'(idx), ondemand_mk[idx], 1);
                invalid_mk[idx] = !good;
                busy_mk[idx] = 0;
                ondemand_mk[idx] = 0;
                delayed_mk[idx] = dw;
                if (!on_list(idx))
                begin
                    if (good && !dw)
                        free_list.push_back(idx);
                    else
                        free_list.push_front(idx);
                end
                return;
            end
            for (int i = 0; i < NB; i++)
            begin
                if (assigned_mk[i] && tag_dev[i] == dev && tag_blk[i] == blk)
                begin
                    if (busy_mk[i])
                    begin
                        ondemand_mk[i] = 1;
                        push(RK_WAIT_BUSY, i, 0, 1);
                    end
                    else
                    begin
                        busy_mk[i] = 1;
                        drop_free(i);
                        push(RK_HIT, i, 0, 1);
                    end
                    return;
                end
            end
            while (free_list.size() > 0)
            begin
                h = free_list.pop_front();
                busy_mk[h] = 1;
                if (delayed_mk[h])
                begin
                    push(RK_WRITEBACK, h, 0, 0);
                    continue;
                end
                tag_dev[h] = dev;
                tag_blk[h] = blk;
                assigned_mk[h] = 1;
                invalid_mk[h] = 1;
                push(RK_FRESH, h, 0, 1);
                return;
            end
            push(RK_WAIT_ANY, 0, 0, 1);
        endfunction

        task check_result(logic [2:0] k, logic [4:0] b, logic w, logic f);
            cache_result_t e;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d buffer %0d", k, b));
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
                report_mismatch($sformatf("result_kind %0d, expected %0d", k, e.kind));
            if (b !== e.buf_idx)
                report_mismatch($sformatf("granted_buffer %0d, expected %0d", b, e.buf_idx));
            if (w !== e.waiters)
                report_mismatch($sformatf("waiters_pending %0d, expected %0d", w, e.waiters));
            if (f !== e.fin)
                report_mismatch($sformatf("last %0d, expected %0d", f, e.fin));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        command = 0;
    logic [15:0] device_number = 0;
    logic [31:0] block_number = 0;
    logic [4:0]  buffer_index = 0;
    logic        contents_valid = 0;
    logic        delayed_write = 0;
    logic        result_valid;
    logic [2:0]  result_kind;
    logic [4:0]  granted_buffer;
    logic        waiters_pending;
    logic        last;

    cache_scoreboard cache_model = new();
    int idle_cycles = 0;
    logic [31:0] tag_pool_blk [8];
    logic [15:0] tag_pool_dev [8];

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    block_buffer_cache_manager_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .device_number(device_number), .block_number(block_number),
        .buffer_index(buffer_index), .contents_valid(contents_valid),
        .delayed_write(delayed_write), .result_valid(result_valid),
        .result_kind(result_kind), .granted_buffer(granted_buffer),
        .waiters_pending(waiters_pending), .last(last)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                cache_model.check_result(result_kind, granted_buffer, waiters_pending, last);
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_block_buffer_cache_manager_core: errors");
                $finish;
            end
        end
    end

    task automatic gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            start <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(logic cmd, logic [15:0] dev, logic [31:0] blk, logic [4:0] idx,
                        logic good, logic dw);
        start <= 1;
        command <= cmd;
        device_number <= dev;
        block_number <= blk;
        buffer_index <= idx;
        contents_valid <= good;
        delayed_write <= dw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        cache_model.note_transaction(cmd, dev, blk, idx, good, dw);
        gap();
    endtask

    task automatic get_block(logic [15:0] dev, logic [31:0] blk);
        send(CMD_GET, dev, blk, 5'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic release_block(logic [4:0] idx, logic good, logic dw);
        send(CMD_RELEASE, 16'($urandom), $urandom, idx, good, dw);
    endtask

    initial
    begin
        int pick;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < 8; i++)
        begin
            tag_pool_dev[i] = 16'($urandom);
            tag_pool_blk[i] = $urandom;
        end
        // directed: extremes, hit, wait busy, rejects, write-back, wait any
        get_block(16'h0000, 32'h0000_0000);
        get_block(16'hFFFF, 32'hFFFF_FFFF);
        get_block(16'hFFFF, 32'hFFFF_FFFF);
        release_block(5'd1, 1, 0);
        release_block(5'd1, 1, 0);
        release_block(5'd31, 0, 1);
        get_block(16'hFFFF, 32'hFFFF_FFFF);
        release_block(5'd1, 0, 1);
        release_block(5'd0, 1, 1);
        get_block(16'h1234, 32'h89AB_CDEF);
        get_block(16'h0000, 32'h0000_0000);
        release_block(5'd0, 0, 0);
        get_block(16'h0000, 32'h0000_0000);
        for (int i = 0; i < 8; i++)
            release_block(i[4:0], 1, 1);
        for (int i = 0; i < 34; i++)
            get_block(16'h5A5A, 32'h1000 + i);
        get_block(16'hA5A5, 32'h5555_AAAA);
        // random: mostly gets over a small tag pool and releases of busy buffers
        for (int n = 0; n < 315; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                int k;
                k = $urandom_range(0, 7);
                get_block(tag_pool_dev[k] ^ 16'(($urandom_range(0, 7) == 0) ? $urandom : 0),
                          tag_pool_blk[k] + $urandom_range(0, 5));
            end
            else if (pick < 8)
            begin
                int busy_list [$];
                for (int i = 0; i < NB; i++)
                    if (cache_model.busy_mk[i])
                        busy_list.push_back(i);
                if (busy_list.size() > 0)
                    release_block(5'(busy_list[$urandom_range(0, busy_list.size() - 1)]),
                                  $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
                else
                    release_block(5'($urandom), 1'($urandom), 1'($urandom));
            end
            else if (pick == 8)
                get_block(16'($urandom), $urandom);
            else
                release_block(5'($urandom), 1'($urandom), 1'($urandom));
        end
        start <= 0;
        while (cache_model.pending.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb_block_buffer_cache_manager_core: clean");
        else
            $display("tb_block_buffer_cache_manager_core: errors");
        $finish;
    end
endmodule

// ===== block_buffer_cache_manager_core.f =====
+incdir+src
src/bbcm_pkg.sv
src/bbcm_cell.sv
src/bbcm_freelist.sv
src/block_buffer_cache_manager_core.sv
tb/tb_block_buffer_cache_manager_core.sv
